FILE: design/mxa_pkg.sv
// Shared types and constants of the 3x3 matrix ALU.
// Used by every module of the block and by its port checker; no dependencies.
package mxa_pkg;

    // Matrix geometry and fixed-point format
    localparam int DIM       = 3;
    localparam int FRAC_BITS = 16;
    localparam int NELEM     = DIM * DIM;

    // Index widths: element address and row/column counters
    localparam int IDX_W = $clog2(NELEM);
    localparam int RC_W  = (DIM > 1) ? $clog2(DIM) : 1;

    // Accumulator holds DIM full 64-bit products plus the rounding half
    localparam int ACC_W = 64 + $clog2(DIM) + 1;

    // Stream payload widths
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;

    // Operation codes carried in the slave tuser
    typedef enum logic [2:0] {
        F_ADD   = 3'd0,
        F_SUB   = 3'd1,
        F_MUL   = 3'd2,
        F_SCALE = 3'd3,
        F_INC   = 3'd4,
        F_DEC   = 3'd5,
        F_TRANS = 3'd6,
        F_CMP   = 3'd7
    } t_func;

    // Sequencer states
    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    // Tag that travels with each operand pair through the shared unit
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_step;

endpackage

FILE: design/mxa_store.sv
// Operand storage for matrices A and B: one write port, one read port each.
// Read data is registered. Depends on mxa_pkg.
module mxa_store (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [mxa_pkg::IDX_W-1:0]    i_waddr,
    input  logic signed [31:0]           i_a_wdata,
    input  logic signed [31:0]           i_b_wdata,
    input  logic [mxa_pkg::IDX_W-1:0]    i_a_raddr,
    input  logic [mxa_pkg::IDX_W-1:0]    i_b_raddr,
    output logic signed [31:0]           o_a_rdata,
    output logic signed [31:0]           o_b_rdata
);

    logic signed [31:0] r_a_mem [mxa_pkg::NELEM];
    logic signed [31:0] r_b_mem [mxa_pkg::NELEM];

    // Write both matrices at the load position
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_a_mem[i_waddr] <= i_a_wdata;
            r_b_mem[i_waddr] <= i_b_wdata;
        end
    end

    // Registered reads
    always_ff @(posedge i_clk) begin
        o_a_rdata <= r_a_mem[i_a_raddr];
        o_b_rdata <= r_b_mem[i_b_raddr];
    end

endmodule

FILE: design/mxa_alu.sv
// Shared arithmetic unit: one 32x32 multiplier, one adder and a compare in
// stage 1, accumulator and compare decision in stage 2. Depends on mxa_pkg.
module mxa_alu (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mxa_pkg::t_func       i_func,
    input  logic signed [15:0]   i_scale,
    input  mxa_pkg::t_step       i_step,
    input  logic signed [31:0]   i_a,
    input  logic signed [31:0]   i_b,
    output logic signed [31:0]   o_value,
    output logic                 o_less,
    output logic                 o_done
);

    localparam logic signed [33:0] ONE = 34'sd1 <<< mxa_pkg::FRAC_BITS;
    localparam logic signed [mxa_pkg::ACC_W-1:0] HALF =
        mxa_pkg::ACC_W'(1) <<< (mxa_pkg::FRAC_BITS - 1);

    // Clamp a wide value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(
        input logic signed [mxa_pkg::ACC_W-1:0] v);
        logic signed [mxa_pkg::ACC_W-1:0] hi;
        logic signed [mxa_pkg::ACC_W-1:0] lo;
        hi = mxa_pkg::ACC_W'(32'sh7fff_ffff);
        lo = mxa_pkg::ACC_W'(32'sh8000_0000);
        if (v > hi) begin
            sat32 = 32'sh7fff_ffff;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    logic signed [31:0]               mul_opnd;
    logic signed [33:0]               addend;
    logic signed [33:0]               n_sum;
    logic signed [63:0]               n_prod;

    logic signed [63:0]               r_prod;
    logic signed [33:0]               r_sum;
    logic signed [31:0]               r_a;
    logic                             r_lt;
    logic                             r_gt;
    mxa_pkg::t_step                   r_step;

    logic signed [mxa_pkg::ACC_W-1:0] r_acc;
    logic signed [mxa_pkg::ACC_W-1:0] prod_ext;
    logic signed [mxa_pkg::ACC_W-1:0] shifted;
    logic                             r_flag;
    logic                             r_decided;
    logic                             r_done;

    // Select multiplier and adder operands
    always_comb begin
        mul_opnd = (i_func == mxa_pkg::F_MUL) ? i_b : 32'(i_scale);
        unique case (i_func)
            mxa_pkg::F_ADD: addend = 34'(i_b);
            mxa_pkg::F_SUB: addend = -34'(i_b);
            mxa_pkg::F_INC: addend = ONE;
            mxa_pkg::F_DEC: addend = -ONE;
            default:        addend = '0;
        endcase
        n_sum  = 34'(i_a) + addend;
        n_prod = 64'(i_a) * 64'(mul_opnd);
    end

    // Stage 1: register product, sum and compare
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_sum  <= n_sum;
        r_a    <= i_a;
        r_lt   <= (i_a < i_b);
        r_gt   <= (i_a > i_b);
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= i_step;
        end
    end

    assign prod_ext = mxa_pkg::ACC_W'(r_prod);

    // Stage 2: accumulate, or take the single-step result
    always_ff @(posedge i_clk) begin
        if (r_step.valid) begin
            unique case (i_func)
                mxa_pkg::F_MUL: begin
                    r_acc <= r_step.first ? (prod_ext + HALF) : (r_acc + prod_ext);
                end
                mxa_pkg::F_SCALE: r_acc <= prod_ext;
                mxa_pkg::F_TRANS: r_acc <= mxa_pkg::ACC_W'(r_a);
                mxa_pkg::F_CMP: begin
                    if (r_step.first || !r_decided) begin
                        r_flag    <= r_lt;
                        r_decided <= r_lt | r_gt;
                    end
                end
                default:          r_acc <= mxa_pkg::ACC_W'(r_sum);
            endcase
        end
    end

    // Pulse when the last step of an element leaves stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_step.valid & r_step.last;
        end
    end

    // Drop fraction bits of the product sum, then saturate
    assign shifted = (i_func == mxa_pkg::F_MUL) ? (r_acc >>> mxa_pkg::FRAC_BITS) : r_acc;
    assign o_value = sat32(shifted);
    assign o_less  = r_flag;
    assign o_done  = r_done;

endmodule

FILE: design/matrix3x3_alu.sv
// Top level of the 3x3 matrix ALU: load counter, sequencer and output register.
// Instantiates mxa_store and mxa_alu; depends on mxa_pkg.
//
// Usage:
//   Slave stream: each transaction carries one element of A and one of B
//   (tdata, row-major) plus the opcode (tuser). The ninth transaction
//   completes the load; its opcode and scale factor select the operation.
//   Master stream: nine result elements in row-major order with row and
//   column, or a single compare flag; tlast marks the final result.
// Timing:
//   Loading accepts one element per cycle while s_axis_tvalid is high. Each
//   result element then passes K operand steps through the shared
//   multiply/add unit, where K is 3 for the matrix product, 9 for the
//   compare (one result) and 1 otherwise. The unit works on one element
//   at a time: the sequencer issues its steps, waits for the result and
//   emits it before the next element begins.
//   s_axis_tready is high only while loading; the next load may begin while
//   the final result still waits in the output register.
// Reset: synchronous, active low; clears the load position and the
//   sequencer and drops m_axis_tvalid. Stored matrices are not cleared.
// Stall: while m_axis_tready is low the result is held and the sequencer
//   waits before loading the next one.
module matrix3x3_alu (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] a_elem, [63:32] b_elem, [79:64] scale_factor
    input  logic [mxa_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] func
    input  logic [mxa_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] value, [33:32] row, [35:34] col, [36] less, [39:37] zero
    output logic [mxa_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast
);

    localparam logic [mxa_pkg::IDX_W-1:0] POS_LAST   = mxa_pkg::IDX_W'(mxa_pkg::NELEM - 1);
    localparam logic [mxa_pkg::IDX_W-1:0] K_MUL_LAST = mxa_pkg::IDX_W'(mxa_pkg::DIM - 1);
    localparam logic [mxa_pkg::IDX_W-1:0] K_CMP_LAST = mxa_pkg::IDX_W'(mxa_pkg::NELEM - 1);
    localparam logic [mxa_pkg::RC_W-1:0]  RC_LAST    = mxa_pkg::RC_W'(mxa_pkg::DIM - 1);

    mxa_pkg::t_state              r_state;
    logic [mxa_pkg::IDX_W-1:0]    r_pos;
    mxa_pkg::t_func               r_func;
    logic signed [15:0]           r_sf;
    logic [mxa_pkg::RC_W-1:0]     r_row;
    logic [mxa_pkg::RC_W-1:0]     r_col;
    logic [mxa_pkg::IDX_W-1:0]    r_k;
    mxa_pkg::t_step               r_step;
    mxa_pkg::t_step               n_step;

    logic                         r_out_valid;
    logic signed [31:0]           r_out_value;
    logic [1:0]                   r_out_row;
    logic [1:0]                   r_out_col;
    logic                         r_out_less;
    logic                         r_out_last;

    logic                         in_accept;
    logic                         out_free;
    logic [mxa_pkg::IDX_W-1:0]    k_last;
    logic [mxa_pkg::IDX_W-1:0]    a_raddr;
    logic [mxa_pkg::IDX_W-1:0]    b_raddr;
    logic                         is_final;
    logic signed [31:0]           rd_a;
    logic signed [31:0]           rd_b;
    logic signed [31:0]           alu_value;
    logic                         alu_less;
    logic                         alu_done;

    assign s_axis_tready = (r_state == mxa_pkg::S_LOAD);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Index of the last operand step per result element
    always_comb begin
        if (r_func == mxa_pkg::F_MUL) begin
            k_last = K_MUL_LAST;
        end else if (r_func == mxa_pkg::F_CMP) begin
            k_last = K_CMP_LAST;
        end else begin
            k_last = '0;
        end
    end

    // Operand addresses for the current element and step
    always_comb begin
        unique case (r_func)
            mxa_pkg::F_MUL: begin
                a_raddr = mxa_pkg::IDX_W'(int'(r_row) * mxa_pkg::DIM + int'(r_k));
                b_raddr = mxa_pkg::IDX_W'(int'(r_k) * mxa_pkg::DIM + int'(r_col));
            end
            mxa_pkg::F_TRANS: begin
                a_raddr = mxa_pkg::IDX_W'(int'(r_col) * mxa_pkg::DIM + int'(r_row));
                b_raddr = a_raddr;
            end
            mxa_pkg::F_CMP: begin
                a_raddr = r_k;
                b_raddr = r_k;
            end
            default: begin
                a_raddr = mxa_pkg::IDX_W'(int'(r_row) * mxa_pkg::DIM + int'(r_col));
                b_raddr = a_raddr;
            end
        endcase
    end

    assign is_final = (r_func == mxa_pkg::F_CMP) || ((r_row == RC_LAST) && (r_col == RC_LAST));

    // Step tag issued this cycle
    always_comb begin
        n_step.valid = (r_state == mxa_pkg::S_ISSUE);
        n_step.first = (r_k == '0);
        n_step.last  = (r_k == k_last);
    end

    // Sequencer: load, issue operand steps, wait for the unit, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mxa_pkg::S_LOAD;
            r_pos   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                mxa_pkg::S_LOAD: begin
                    if (in_accept) begin
                        if (r_pos == POS_LAST) begin
                            r_pos   <= '0;
                            r_func  <= mxa_pkg::t_func'(s_axis_tuser);
                            r_sf    <= s_axis_tdata[79:64];
                            r_row   <= '0;
                            r_col   <= '0;
                            r_k     <= '0;
                            r_state <= mxa_pkg::S_ISSUE;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                mxa_pkg::S_ISSUE: begin
                    if (r_k == k_last) begin
                        r_k     <= '0;
                        r_state <= mxa_pkg::S_WAIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                mxa_pkg::S_WAIT: begin
                    if (alu_done) begin
                        r_state <= mxa_pkg::S_EMIT;
                    end
                end
                mxa_pkg::S_EMIT: begin
                    if (out_free) begin
                        if (is_final) begin
                            r_row   <= '0;
                            r_col   <= '0;
                            r_state <= mxa_pkg::S_LOAD;
                        end else begin
                            if (r_col == RC_LAST) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                            r_state <= mxa_pkg::S_ISSUE;
                        end
                    end
                end
                default: r_state <= mxa_pkg::S_LOAD;
            endcase
        end
    end

    // Align step tag with registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

    // Output register: load a result, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == mxa_pkg::S_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == mxa_pkg::S_EMIT) && out_free) begin
            r_out_last <= is_final;
            if (r_func == mxa_pkg::F_CMP) begin
                r_out_value <= '0;
                r_out_row   <= '0;
                r_out_col   <= '0;
                r_out_less  <= alu_less;
            end else begin
                r_out_value <= alu_value;
                r_out_row   <= 2'(r_row);
                r_out_col   <= 2'(r_col);
                r_out_less  <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {3'b000, r_out_less, r_out_col, r_out_row, r_out_value};

    mxa_store u_store (
        .i_clk     (i_clk),
        .i_we      (in_accept),
        .i_waddr   (r_pos),
        .i_a_wdata (s_axis_tdata[31:0]),
        .i_b_wdata (s_axis_tdata[63:32]),
        .i_a_raddr (a_raddr),
        .i_b_raddr (b_raddr),
        .o_a_rdata (rd_a),
        .o_b_rdata (rd_b)
    );

    mxa_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_func  (r_func),
        .i_scale (r_sf),
        .i_step  (r_step),
        .i_a     (rd_a),
        .i_b     (rd_b),
        .o_value (alu_value),
        .o_less  (alu_less),
        .o_done  (alu_done)
    );

endmodule

FILE: design/mxa_checker.sv
// Port-level checker for matrix3x3_alu and the bind that attaches it.
// Depends on mxa_pkg.
module mxa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mxa_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input logic                            m_axis_tlast
);

    // Hold a stalled result transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Drop the result stream after reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A compare flag appears only on a lone final result with zero value
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[36] |->
            m_axis_tlast && (m_axis_tdata[35:0] == 36'd0))
        else $error("compare result malformed");

    // Row and column stay inside the matrix, padding stays zero
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[33:32] < mxa_pkg::DIM) && (m_axis_tdata[35:34] < mxa_pkg::DIM)
            && (m_axis_tdata[39:37] == 3'd0))
        else $error("result index out of range");

    // No new load while a non-final element result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("load accepted during result burst");

endmodule

bind matrix3x3_alu mxa_checker u_mxa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/matrix3x3_alu_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for matrix3x3_alu: directed corner matrices, then random operations.
// Holds its own Q16.16 matrix predictor in a scoreboard class; depends on mxa_pkg and the RTL.

typedef logic signed [31:0] t_q16;
typedef t_q16 t_mat [mxa_pkg::NELEM];

// One expected master transaction
typedef struct packed {
    logic [31:0] value;
    logic [1:0]  row;
    logic [1:0]  col;
    logic        less;
    logic        last;
} t_result;

localparam t_q16 Q_MAX = 32'sh7FFF_FFFF;
localparam t_q16 Q_MIN = 32'sh8000_0000;
localparam t_q16 Q_ONE = 32'sd1 <<< mxa_pkg::FRAC_BITS;

// Tracks the loaded matrices and queues the results each completed load must produce
class matrix_scoreboard;
    t_q16        a_mat [mxa_pkg::NELEM];
    t_q16        b_mat [mxa_pkg::NELEM];
    int unsigned load_pos;
    t_result     expected_q [$];
    int unsigned errors;
    int unsigned results_checked;
    int unsigned op_count [8];

    function new();
        load_pos        = 0;
        errors          = 0;
        results_checked = 0;
        foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Clamp a wide signed value to the 32-bit Q16.16 range
    function t_q16 saturate(logic signed [67:0] v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v[31:0];
    endfunction

    // Exact row-by-column sum, rounded half up at the binary point
    function logic signed [67:0] product_elem(int r, int c);
        logic signed [67:0] sum;
        logic signed [67:0] wa;
        logic signed [67:0] wb;
        sum = '0;
        for (int k = 0; k < mxa_pkg::DIM; k++) begin
            wa  = a_mat[r * mxa_pkg::DIM + k];
            wb  = b_mat[k * mxa_pkg::DIM + c];
            sum = sum + wa * wb;
        end
        sum = sum + (68'sd1 <<< (mxa_pkg::FRAC_BITS - 1));
        return sum >>> mxa_pkg::FRAC_BITS;
    endfunction

    // Store one accepted element pair; on the completing one, predict the results
    function void note_load(mxa_pkg::t_func func, t_q16 a, t_q16 b, logic signed [15:0] sf);
        t_result            nxt;
        logic signed [67:0] wa;
        logic signed [67:0] wb;
        logic signed [67:0] wsf;
        logic signed [67:0] wide;
        logic               flag;
        int                 i;
        a_mat[load_pos] = a;
        b_mat[load_pos] = b;
        if (load_pos < mxa_pkg::NELEM - 1) begin
            load_pos++;
            return;
        end
        load_pos = 0;
        op_count[func]++;

        // Lexicographic compare yields one flag transaction
        if (func == mxa_pkg::F_CMP) begin
            flag = 1'b0;
            for (i = 0; i < mxa_pkg::NELEM; i++) begin
                if (a_mat[i] != b_mat[i]) begin
                    flag = (a_mat[i] < b_mat[i]);
                    break;
                end
            end
            nxt       = '0;
            nxt.less  = flag;
            nxt.last  = 1'b1;
            expected_q.push_back(nxt);
            return;
        end

        // Element results in row-major order
        wsf = sf;
        for (int r = 0; r < mxa_pkg::DIM; r++) begin
            for (int c = 0; c < mxa_pkg::DIM; c++) begin
                i  = r * mxa_pkg::DIM + c;
                wa = a_mat[i];
                wb = b_mat[i];
                case (func)
                    mxa_pkg::F_ADD:   wide = wa + wb;
                    mxa_pkg::F_SUB:   wide = wa - wb;
                    mxa_pkg::F_MUL:   wide = product_elem(r, c);
                    mxa_pkg::F_SCALE: wide = wa * wsf;
                    mxa_pkg::F_INC:   wide = wa + Q_ONE;
                    mxa_pkg::F_DEC:   wide = wa - Q_ONE;
                    default:          wide = a_mat[c * mxa_pkg::DIM + r];
                endcase
                nxt.value = saturate(wide);
                nxt.row   = 2'(r);
                nxt.col   = 2'(c);
                nxt.less  = 1'b0;
                nxt.last  = (i == mxa_pkg::NELEM - 1);
                expected_q.push_back(nxt);
            end
        end
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Compare one accepted master transaction with the oldest expectation
    function void check_result(logic [mxa_pkg::M_TDATA_W-1:0] tdata, logic tlast);
        t_result exp_r;
        if (expected_q.size() == 0) begin
            $error("unexpected result: tdata=0x%0h tlast=%0b", tdata, tlast);
            errors++;
            return;
        end
        exp_r = expected_q.pop_front();
        results_checked++;
        check_field("value", exp_r.value, tdata[31:0]);
        check_field("row", 32'(exp_r.row), 32'(tdata[33:32]));
        check_field("col", 32'(exp_r.col), 32'(tdata[35:34]));
        check_field("less", 32'(exp_r.less), 32'(tdata[36]));
        check_field("pad", 32'd0, 32'(tdata[39:37]));
        check_field("last", 32'(exp_r.last), 32'(tlast));
    endfunction
endclass

module matrix3x3_alu_test;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_OPS     = 4;     // per idle/stall phase
    localparam int TAIL_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TX_IDLE  [4]   = '{0, 79, 0, 32};
    localparam int RX_STALL [4]   = '{0, 0, 79, 32};

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [mxa_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [mxa_pkg::S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [mxa_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                          m_axis_tlast;

    int                   tx_idle_pct  = 0;
    int                   rx_stall_pct = 0;
    int unsigned          items_sent   = 0;
    int unsigned          quiet_cycles = 0;
    matrix_scoreboard     board        = new();

    matrix3x3_alu u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Stall the result stream at random
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Check every accepted result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tlast);
    end

    // Abort when no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Element drawn from small values (0), corner values (1) or the full range (2)
    function automatic t_q16 rand_elem(int style);
        case (style)
            0: return t_q16'($urandom_range(12 * 65536)) - (6 <<< mxa_pkg::FRAC_BITS);
            1: begin
                case ($urandom_range(4))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            default: return t_q16'($urandom);
        endcase
    endfunction

    // Drive one element pair; called and returning at a falling edge
    task automatic send_item(mxa_pkg::t_func func, t_q16 a, t_q16 b, logic [15:0] sf);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {16'($urandom), $urandom, $urandom};
            s_axis_tuser  <= 3'($urandom);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sf, b, a};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_load(func, a, b, sf);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Load both matrices; opcode and scale travel on the last element, noise elsewhere
    task automatic run_op(mxa_pkg::t_func func, logic [15:0] sf, t_mat a_m, t_mat b_m);
        for (int i = 0; i < mxa_pkg::NELEM; i++) begin
            if (i == mxa_pkg::NELEM - 1)
                send_item(func, a_m[i], b_m[i], sf);
            else
                send_item(mxa_pkg::t_func'($urandom_range(7)), a_m[i], b_m[i],
                          16'($urandom));
        end
    endtask

    initial begin
        t_mat           a_m;
        t_mat           b_m;
        t_mat           corner_m;
        mxa_pkg::t_func f;
        logic [15:0]    sf;
        int             op_style;
        int             k;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: saturation both ways, rounding of the half, signed compare
        corner_m = '{Q_MAX, Q_MIN, 0, Q_ONE, -Q_ONE, 1, -1, 32'sh7FFF_0000, 32'sh8000_FFFF};
        a_m = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, Q_ONE, -Q_ONE, Q_MAX, 3};
        b_m = '{Q_MAX, Q_MIN, Q_MIN, Q_MAX, 0, Q_ONE, Q_ONE, -1, -7};
        run_op(mxa_pkg::F_ADD, 16'd0, a_m, b_m);
        run_op(mxa_pkg::F_SUB, 16'd0, a_m, b_m);
        a_m = '{Q_MIN, Q_MIN, Q_MIN, 1, 1, 1, Q_ONE, 0, 0};
        b_m = '{Q_MIN, Q_MAX, 32'sh8000, Q_MIN, Q_MAX, -32'sh8000, Q_MIN, Q_MAX, 32'sh8000};
        run_op(mxa_pkg::F_MUL, 16'd0, a_m, b_m);
        run_op(mxa_pkg::F_SCALE, 16'h8000, corner_m, b_m);
        run_op(mxa_pkg::F_SCALE, 16'h7FFF, corner_m, b_m);
        run_op(mxa_pkg::F_INC, 16'd0, corner_m, b_m);
        run_op(mxa_pkg::F_DEC, 16'd0, corner_m, b_m);
        run_op(mxa_pkg::F_TRANS, 16'd0, corner_m, b_m);
        run_op(mxa_pkg::F_CMP, 16'd0, corner_m, corner_m);
        b_m = corner_m;
        b_m[mxa_pkg::NELEM - 1] = corner_m[mxa_pkg::NELEM - 1] + 1;
        run_op(mxa_pkg::F_CMP, 16'd0, corner_m, b_m);

        // Random operations under each idle/stall mix
        for (int p = 0; p < 4; p++) begin
            tx_idle_pct  = TX_IDLE[p];
            rx_stall_pct = RX_STALL[p];
            repeat (RANDOM_OPS) begin
                f        = mxa_pkg::t_func'($urandom_range(7));
                op_style = $urandom_range(3);
                sf       = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(16) - 8);
                for (k = 0; k < mxa_pkg::NELEM; k++) begin
                    a_m[k] = rand_elem(op_style == 3 ? $urandom_range(2) : op_style);
                    b_m[k] = rand_elem(op_style == 3 ? $urandom_range(2) : op_style);
                end
                // Make compares close: equal, or differing in one spot
                if (f == mxa_pkg::F_CMP && $urandom_range(1)) begin
                    b_m = a_m;
                    k   = $urandom_range(mxa_pkg::NELEM);
                    if (k < mxa_pkg::NELEM)
                        b_m[k] = a_m[k] + t_q16'($urandom_range(4)) - 2;
                end
                run_op(f, sf, a_m, b_m);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then hold off to catch any stray result
        while (board.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Loaded %0d element pairs; checked %0d results across four idle/stall mixes.",
                 items_sent, board.results_checked);
        $display("Ops: add %0d sub %0d mul %0d scale %0d inc %0d dec %0d trans %0d cmp %0d",
                 board.op_count[mxa_pkg::F_ADD], board.op_count[mxa_pkg::F_SUB],
                 board.op_count[mxa_pkg::F_MUL], board.op_count[mxa_pkg::F_SCALE],
                 board.op_count[mxa_pkg::F_INC], board.op_count[mxa_pkg::F_DEC],
                 board.op_count[mxa_pkg::F_TRANS], board.op_count[mxa_pkg::F_CMP]);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
